FILE: src/lasm_pkg.sv
// ----------------------------------------------------------------------------
// lasm_pkg
// Shared types and constants of the light action state machine: light
// states, action codes, register indexes and the item, result and state
// records passed between the top level and the step logic.
// ----------------------------------------------------------------------------
package lasm_pkg;

	localparam int TIMER_W = 27;
	localparam logic [7:0] MOVEMENT_DEFAULT_MS = 8'd10;
	localparam int MS_PER_SECOND = 1000;

	typedef enum logic [2:0] {
		ST_OFF      = 3'd0,
		ST_ON_INIT  = 3'd1,
		ST_ON       = 3'd2,
		ST_OFF_INIT = 3'd3,
		ST_LEVEL    = 3'd4,
		ST_MODE     = 3'd5,
		ST_TEMP     = 3'd6,
		ST_COLOR    = 3'd7
	} light_state_t;

	typedef enum logic [2:0] {
		ACT_NONE  = 3'd0,
		ACT_ON    = 3'd1,
		ACT_OFF   = 3'd2,
		ACT_LEVEL = 3'd3,
		ACT_MODE  = 3'd4,
		ACT_TEMP  = 3'd5,
		ACT_COLOR = 3'd6
	} led_act_t;

	typedef enum logic [2:0] {
		CODE_ON    = 3'd0,
		CODE_LEVEL = 3'd1,
		CODE_OFF   = 3'd2,
		CODE_MODE  = 3'd3,
		CODE_TEMP  = 3'd4,
		CODE_COLOR = 3'd5
	} code_t;

	typedef enum logic [1:0] {
		REG_AUTO_OFF_EN  = 2'd0,
		REG_AUTO_OFF_SEC = 2'd1,
		REG_MOVEMENT_MS  = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic        req_type;
		logic [2:0]  action_code;
		logic [7:0]  action_value;
		logic [23:0] color_rgb;
		logic [15:0] actor_id;
	} item_t;

	typedef struct packed {
		logic        accepted;
		led_act_t    started_action;
		logic [15:0] started_actor;
		led_act_t    completed_action;
		led_act_t    led_cmd;
		logic [7:0]  led_value;
		logic [23:0] led_color;
		light_state_t light_state;
	} result_t;

	typedef struct packed {
		light_state_t        mode;
		logic [TIMER_W-1:0]  timer_ms;
		logic                running;
		logic                armed;
	} state_t;

	typedef struct packed {
		logic                auto_off_en;
		logic [TIMER_W-1:0]  auto_off_ms;
		logic [7:0]          movement_ms;
	} cfg_t;

endpackage

FILE: src/lasm_in_if.sv
// ----------------------------------------------------------------------------
// lasm_in_if
// Input channel: one tick or one action request per item.
// ----------------------------------------------------------------------------
interface lasm_in_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [2:0]  action_code;
	logic [7:0]  action_value;
	logic [23:0] color_rgb;
	logic [15:0] actor_id;

	modport source (output valid, req_type, action_code, action_value, color_rgb, actor_id,
		input ready);
	modport sink (input valid, req_type, action_code, action_value, color_rgb, actor_id,
		output ready);
endinterface

FILE: src/lasm_out_if.sv
// ----------------------------------------------------------------------------
// lasm_out_if
// Output channel: one result item for every input item.
// ----------------------------------------------------------------------------
interface lasm_out_if;
	logic        valid;
	logic        ready;
	logic        accepted;
	logic [2:0]  started_action;
	logic [15:0] started_actor;
	logic [2:0]  completed_action;
	logic [2:0]  led_cmd;
	logic [7:0]  led_value;
	logic [23:0] led_color;
	logic [2:0]  light_state;

	modport source (output valid, accepted, started_action, started_actor,
		completed_action, led_cmd, led_value, led_color, light_state, input ready);
	modport sink (input valid, accepted, started_action, started_actor,
		completed_action, led_cmd, led_value, led_color, light_state, output ready);
endinterface

FILE: src/lasm_step.sv
// ----------------------------------------------------------------------------
// lasm_step
// Combinational step of the light state machine: from the current state,
// one item and the configuration, forms the next state and the result.
// ----------------------------------------------------------------------------
module lasm_step (
	input  lasm_pkg::state_t  cur,
	input  lasm_pkg::item_t   item,
	input  lasm_pkg::cfg_t    cfg,
	output lasm_pkg::state_t  nxt,
	output lasm_pkg::result_t res
);
	import lasm_pkg::*;

	logic               tick_run;
	logic [TIMER_W-1:0] rem_dec;
	logic               expire;
	logic               auto_init;
	logic               try_init;
	logic [2:0]         code;
	logic [7:0]         value;
	logic [23:0]        rgb;
	logic [15:0]        actor;
	logic               ok;
	light_state_t       init_ns;
	led_act_t           rep;
	logic               complete;
	led_act_t           done;
	light_state_t       done_ns;
	logic               arm;
	logic [TIMER_W-1:0] move_load;
	logic [TIMER_W-1:0] aoff_load;

	// Tick countdown and expiry.
	assign tick_run  = !item.req_type && cur.running;
	assign rem_dec   = cur.timer_ms - TIMER_W'(cur.timer_ms != '0);
	assign expire    = tick_run && (rem_dec == '0);
	assign auto_init = expire && cur.armed;
	assign complete  = expire && !cur.armed;

	// An armed expiry issues an off request from actor zero.
	assign try_init = item.req_type || auto_init;
	assign code     = item.req_type ? item.action_code : CODE_OFF;
	assign value    = item.req_type ? item.action_value : 8'd0;
	assign rgb      = item.req_type ? item.color_rgb : 24'd0;
	assign actor    = item.req_type ? item.actor_id : 16'd0;

	assign move_load = (cfg.movement_ms == 8'd0) ? TIMER_W'(1) : TIMER_W'(cfg.movement_ms);
	assign aoff_load = (cfg.auto_off_ms == '0) ? TIMER_W'(1) : cfg.auto_off_ms;

	// Request admission against the current light state.
	always_comb begin
		ok      = 1'b0;
		init_ns = ST_OFF;
		rep     = ACT_NONE;
		case (code_t'(code))
			CODE_ON: begin
				rep = ACT_ON;
				if (cur.mode == ST_OFF) begin
					ok = 1'b1; init_ns = ST_ON_INIT;
				end else if (value != 8'd0 && cur.mode == ST_ON) begin
					ok = 1'b1; init_ns = ST_LEVEL;
				end
			end
			CODE_LEVEL: begin
				rep = ACT_LEVEL;
				ok = (cur.mode == ST_ON); init_ns = ST_LEVEL;
			end
			CODE_OFF: begin
				rep = ACT_OFF;
				ok = (cur.mode == ST_ON); init_ns = ST_OFF_INIT;
			end
			CODE_MODE: begin
				rep = ACT_MODE;
				ok = (cur.mode == ST_ON); init_ns = ST_MODE;
			end
			CODE_TEMP: begin
				rep = ACT_TEMP;
				ok = (cur.mode == ST_ON); init_ns = ST_TEMP;
			end
			CODE_COLOR: begin
				rep = ACT_COLOR;
				ok = 1'b1; init_ns = ST_COLOR;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		ok = ok && try_init;
	end

	// Completion of an initiated state.
	always_comb begin
		done    = ACT_NONE;
		done_ns = cur.mode;
		case (cur.mode)
			ST_OFF_INIT: begin done = ACT_OFF;   done_ns = ST_OFF; end
			ST_ON_INIT:  begin done = ACT_ON;    done_ns = ST_ON; end
			ST_LEVEL:    begin done = ACT_LEVEL; done_ns = ST_ON; end
			ST_MODE:     begin done = ACT_MODE;  done_ns = ST_ON; end
			ST_TEMP:     begin done = ACT_TEMP;  done_ns = ST_ON; end
			ST_COLOR:    begin done = ACT_COLOR; done_ns = ST_ON; end
			default:     begin done = ACT_NONE;  done_ns = cur.mode; end
		endcase
	end

	assign arm = complete && done != ACT_NONE && done != ACT_OFF && cfg.auto_off_en;

	// Next state.
	always_comb begin
		nxt = cur;
		if (tick_run) begin
			nxt.timer_ms = rem_dec;
		end
		if (expire) begin
			nxt.running = 1'b0;
			nxt.armed   = 1'b0;
		end
		if (ok) begin
			nxt.mode     = init_ns;
			nxt.armed    = 1'b0;
			nxt.timer_ms = move_load;
			nxt.running  = 1'b1;
		end else if (complete) begin
			nxt.mode = done_ns;
			if (arm) begin
				nxt.timer_ms = aoff_load;
				nxt.running  = 1'b1;
				nxt.armed    = 1'b1;
			end
		end
	end

	// Result fields.
	always_comb begin
		res = '0;
		if (ok) begin
			res.accepted       = 1'b1;
			res.started_action = rep;
			res.started_actor  = actor;
			case (init_ns)
				ST_ON_INIT:  res.led_cmd = ACT_ON;
				ST_OFF_INIT: res.led_cmd = ACT_OFF;
				ST_MODE: begin
					res.led_cmd   = ACT_MODE;
					res.led_value = {7'd0, value != 8'd0};
				end
				ST_TEMP: begin
					res.led_cmd   = ACT_TEMP;
					res.led_value = value;
				end
				ST_LEVEL: begin
					res.led_cmd   = ACT_LEVEL;
					res.led_value = value;
				end
				default: begin
					res.led_cmd   = ACT_COLOR;
					res.led_color = rgb;
				end
			endcase
		end
		if (complete) begin
			res.completed_action = done;
		end
		res.light_state = nxt.mode;
	end

endmodule

FILE: src/light_action_state_machine.sv
// ----------------------------------------------------------------------------
// light_action_state_machine
// Light controller: takes 1 ms ticks and action requests, runs the movement
// timer and the auto turn-off countdown, and reports one result per item.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake     | Carries
//  --------+-----------+---------------+---------------------------------------
//  in_ch   | sink      | valid / ready | tick or action request with payload
//  out_ch  | source    | valid / ready | initiation, completion, LED command
//  cfg     | write     | cfg_we        | auto-off enable, delay, movement time
//
//  One item per cycle is taken while the output is ready; its result passes
//  from the input register through the state update into the result register,
//  which presents it on the output until it is taken.
//  The state, timer and both pipeline valids clear on arst_n; the movement time
//  resets to 10 ms, auto-off to disabled with a zero delay.
//  A stalled output holds its result; the input register keeps taking items
//  until it is full, so throughput is set only by the output ready.
// ----------------------------------------------------------------------------
module light_action_state_machine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	lasm_in_if.sink     in_ch,
	lasm_out_if.source  out_ch
);
	import lasm_pkg::*;

	// Input register stage.
	logic    valid_s1;
	item_t   item_s1;

	// Result register.
	logic    out_valid_q;
	result_t res_q;

	// Light state and timer.
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;

	// Configuration. The auto-off delay is kept in milliseconds, scaled when
	// it is written so the step logic only has to load it.
	logic               aoff_en_q;
	logic [TIMER_W-1:0] aoff_ms_q;
	logic [7:0]         move_ms_q;
	cfg_t               cfg;

	logic adv;
	logic in_acc;

	// The item in the input register moves on whenever the result register
	// is empty or is being emptied in this cycle.
	assign adv         = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;
	assign in_acc      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.req_type     <= in_ch.req_type;
			item_s1.action_code  <= in_ch.action_code;
			item_s1.action_value <= in_ch.action_value;
			item_s1.color_rgb    <= in_ch.color_rgb;
			item_s1.actor_id     <= in_ch.actor_id;
		end
	end

	// Configuration writes; an index beyond the register list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aoff_en_q <= 1'b0;
			aoff_ms_q <= '0;
			move_ms_q <= MOVEMENT_DEFAULT_MS;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_AUTO_OFF_EN:  aoff_en_q <= cfg_wdata[0];
				REG_AUTO_OFF_SEC: aoff_ms_q <= TIMER_W'(cfg_wdata) * TIMER_W'(MS_PER_SECOND);
				REG_MOVEMENT_MS:  move_ms_q <= cfg_wdata[7:0];
				default:          ;
			endcase
		end
	end

	assign cfg.auto_off_en = aoff_en_q;
	assign cfg.auto_off_ms = aoff_ms_q;
	assign cfg.movement_ms = move_ms_q;

	lasm_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.cfg  (cfg),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// The state advances together with the result it produced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode     <= ST_OFF;
			state_q.timer_ms <= '0;
			state_q.running  <= 1'b0;
			state_q.armed    <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (adv) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_nxt;
		end
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.accepted         = res_q.accepted;
	assign out_ch.started_action   = res_q.started_action;
	assign out_ch.started_actor    = res_q.started_actor;
	assign out_ch.completed_action = res_q.completed_action;
	assign out_ch.led_cmd          = res_q.led_cmd;
	assign out_ch.led_value        = res_q.led_value;
	assign out_ch.led_color        = res_q.led_color;
	assign out_ch.light_state      = res_q.light_state;

`ifndef SYNTHESIS
	// A running timer always has time left to count.
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.running |-> state_q.timer_ms != '0)
		else $error("timer running with zero remaining");

	// Auto-off is only armed while its countdown runs.
	a_armed_running: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.armed |-> state_q.running)
		else $error("auto-off armed without a running timer");

	// Auto-off is armed only after completing into the on state.
	a_armed_on: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.armed |-> state_q.mode == ST_ON)
		else $error("auto-off armed outside the on state");

	// An initiated action always reports its action and an LED command.
	a_accept_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.accepted |->
			res_q.started_action != ACT_NONE && res_q.led_cmd != ACT_NONE)
		else $error("accepted result without action or command");

	// Without an initiation there is no LED command.
	a_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.accepted |-> res_q.led_cmd == ACT_NONE)
		else $error("LED command without an initiated action");
`endif

endmodule
